// ===== rtl/core/masv_pkg.sv =====
// Package: parse phases, status codes, register indexes and field types for the validator.
`default_nettype none
package masv_pkg;

    localparam int HDR_BYTES = 24;

    typedef enum logic [14:0] {
        PH_HEADER   = 15'h0001,
        PH_NAME     = 15'h0002,
        PH_RETNAME  = 15'h0004,
        PH_CUE_LO   = 15'h0008,
        PH_CUE_HI   = 15'h0010,
        PH_CUE_MODE = 15'h0020,
        PH_CUE_NLEN = 15'h0040,
        PH_CUE_NAME = 15'h0080,
        PH_DUR_LO   = 15'h0100,
        PH_DUR_HI   = 15'h0200,
        PH_TCOUNT   = 15'h0400,
        PH_JOINT    = 15'h0800,
        PH_CEN_LO   = 15'h1000,
        PH_CEN_HI   = 15'h2000,
        PH_DONE     = 15'h4000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_VERSION   = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_CHECKSUM  = 3'd4
    } t_status;

    localparam logic [2:0] REG_JMAP_VER  = 3'd0;
    localparam logic [2:0] REG_MAX_FRM   = 3'd1;
    localparam logic [2:0] REG_MAX_EXP   = 3'd2;
    localparam logic [2:0] REG_MAX_CUES  = 3'd3;
    localparam logic [2:0] REG_HIGH_MODE = 3'd4;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [7:0]  SCHEMA_VER = 8'h01;
    localparam logic [7:0]  MAX_REPS   = 8'd16;
    localparam logic [15:0] DUR_MIN    = 16'd20;
    localparam logic [15:0] DUR_MAX    = 16'd5000;
    localparam logic [15:0] CEN_MAX    = 16'd18000;

    typedef struct packed {
        logic [7:0]  jmap_ver;
        logic [15:0] max_frames;
        logic [19:0] max_exp;
        logic [7:0]  max_cues;
        logic [7:0]  high_mode;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] frames;
        logic [7:0]  repeats;
        logic [7:0]  cues;
        logic        ret_pose;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic name_char_ok(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/masv_cfg_regs.sv =====
// Configuration register file for the validator limits.
`default_nettype none
module masv_cfg_regs (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [19:0]     i_cfg_data,
    output masv_pkg::t_cfg       o_cfg
);
    import masv_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jmap_ver   <= 8'd1;
            r_cfg.max_frames <= 16'd256;
            r_cfg.max_exp    <= 20'd1024;
            r_cfg.max_cues   <= 8'd32;
            r_cfg.high_mode  <= 8'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_JMAP_VER:  r_cfg.jmap_ver   <= i_cfg_data[7:0];
                REG_MAX_FRM:   r_cfg.max_frames <= i_cfg_data[15:0];
                REG_MAX_EXP:   r_cfg.max_exp    <= i_cfg_data;
                REG_MAX_CUES:  r_cfg.max_cues   <= i_cfg_data[7:0];
                REG_HIGH_MODE: r_cfg.high_mode  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/masv_parser.sv =====
// Per-byte header capture, CRC, body parser and end-of-file status.
`default_nettype none
module masv_parser #(
    parameter int SERVOS   = 8,
    parameter int NAME_MAX = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_beat,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  masv_pkg::t_cfg     i_cfg,
    output masv_pkg::t_result  o_result
);
    import masv_pkg::*;

    localparam int SW = (SERVOS > 1) ? $clog2(SERVOS) : 1;

    logic [31:0]  r_count, n_count;
    logic [31:0]  r_crc, n_crc;
    logic [7:0]   r_hdr [HDR_BYTES];
    t_phase       r_phase, n_phase;
    logic [15:0]  r_item, n_item;
    logic [7:0]   r_sub, n_sub;
    logic [15:0]  r_hold, n_hold;
    logic [SERVOS-1:0] r_seen, n_seen;
    logic         r_nend, n_nend;
    logic         r_berr, n_berr;

    logic [7:0]   h [HDR_BYTES];
    logic [15:0]  frames, cues, v16;
    logic [8:0]   sub_inc;
    logic         in_hdr;
    logic [4:0]   pos;

    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) h[i] = r_hdr[i];
        in_hdr = (r_count < 32'(HDR_BYTES));
        pos    = r_count[4:0];
        if (in_hdr) h[pos] = i_byte;
    end

    assign frames  = {h[9], h[8]};
    assign cues    = {h[11], h[10]};
    assign v16     = {i_byte, r_hold[7:0]};
    assign sub_inc = {1'b0, r_sub} + 9'd1;

    always_comb begin
        n_count = (r_count == 32'hFFFFFFFF) ? r_count : r_count + 32'd1;
        n_crc   = r_crc;
        n_phase = r_phase;
        n_item  = r_item;
        n_sub   = r_sub;
        n_hold  = r_hold;
        n_seen  = r_seen;
        n_nend  = r_nend;
        n_berr  = r_berr;
        if (in_hdr) begin
            if (pos == 5'(HDR_BYTES - 1)) begin
                if (h[12] == 8'd0 || 32'(h[12]) > 32'(NAME_MAX)) n_berr = 1'b1;
                else begin
                    n_hold = {8'd0, h[12]}; n_sub = 8'd0; n_nend = 1'b0; n_phase = PH_NAME;
                end
            end
        end else begin
            n_crc = crc_byte(r_crc, i_byte);
            if (!r_berr) begin
                case (r_phase)
                    PH_NAME, PH_RETNAME, PH_CUE_NAME: begin
                        if ((r_sub == 8'd0 && i_byte == 8'd0) ||
                            (!r_nend && i_byte != 8'd0 && !name_char_ok(i_byte))) begin
                            n_berr = 1'b1;
                        end else begin
                            if (!r_nend && i_byte == 8'd0) n_nend = 1'b1;
                            n_sub = sub_inc[7:0];
                            if ({8'd0, sub_inc[7:0]} >= r_hold) begin
                                if (r_phase == PH_NAME && h[13] != 8'd0) begin
                                    if (32'(h[13]) > 32'(NAME_MAX)) n_berr = 1'b1;
                                    else begin
                                        n_hold = {8'd0, h[13]}; n_sub = 8'd0;
                                        n_nend = 1'b0; n_phase = PH_RETNAME;
                                    end
                                end else begin
                                    n_item = (r_phase == PH_CUE_NAME) ? r_item + 16'd1 : 16'd0;
                                    if (n_item < cues) n_phase = PH_CUE_LO;
                                    else begin
                                        n_item  = 16'd0;
                                        n_phase = (frames != 16'd0) ? PH_DUR_LO : PH_DONE;
                                    end
                                end
                            end
                        end
                    end
                    PH_CUE_LO: begin n_hold = {8'd0, i_byte}; n_phase = PH_CUE_HI; end
                    PH_CUE_HI: begin
                        if (v16 >= frames) n_berr = 1'b1; else n_phase = PH_CUE_MODE;
                    end
                    PH_CUE_MODE: begin
                        if (i_byte > i_cfg.high_mode) n_berr = 1'b1;
                        else n_phase = PH_CUE_NLEN;
                    end
                    PH_CUE_NLEN: begin
                        if (i_byte == 8'd0 || 32'(i_byte) > 32'(NAME_MAX)) n_berr = 1'b1;
                        else begin
                            n_hold = {8'd0, i_byte}; n_sub = 8'd0;
                            n_nend = 1'b0; n_phase = PH_CUE_NAME;
                        end
                    end
                    PH_DUR_LO: begin n_hold = {8'd0, i_byte}; n_phase = PH_DUR_HI; end
                    PH_DUR_HI: begin
                        if (v16 < DUR_MIN || v16 > DUR_MAX) n_berr = 1'b1;
                        else n_phase = PH_TCOUNT;
                    end
                    PH_TCOUNT: begin
                        if (i_byte == 8'd0 || 32'(i_byte) > 32'(SERVOS)) n_berr = 1'b1;
                        else begin
                            n_hold = {i_byte, 8'd0}; n_sub = 8'd0;
                            n_seen = '0; n_phase = PH_JOINT;
                        end
                    end
                    PH_JOINT: begin
                        if (32'(i_byte) >= 32'(SERVOS) || r_seen[i_byte[SW-1:0]]) n_berr = 1'b1;
                        else begin
                            n_seen[i_byte[SW-1:0]] = 1'b1; n_phase = PH_CEN_LO;
                        end
                    end
                    PH_CEN_LO: begin n_hold = {r_hold[15:8], i_byte}; n_phase = PH_CEN_HI; end
                    PH_CEN_HI: begin
                        if (v16 > CEN_MAX) n_berr = 1'b1;
                        else begin
                            n_sub = sub_inc[7:0];
                            if (sub_inc[7:0] < r_hold[15:8]) n_phase = PH_JOINT;
                            else begin
                                n_item  = r_item + 16'd1;
                                n_phase = (n_item < frames) ? PH_DUR_LO : PH_DONE;
                            end
                        end
                    end
                    default: n_berr = 1'b1;
                endcase
            end
        end
    end

    logic [31:0] payload, plen, crc_hdr;
    logic [23:0] expanded;
    logic        hdr_bad;
    t_status     st;

    assign payload  = n_count - 32'(HDR_BYTES);
    assign plen     = {h[19], h[18], h[17], h[16]};
    assign crc_hdr  = {h[23], h[22], h[21], h[20]};
    assign expanded = {8'd0, frames} * {16'd0, h[6]};
    assign hdr_bad  = (h[7][7:1] != 7'd0) || ({h[15], h[14]} != 16'd0) ||
                      (h[6] == 8'd0) || (h[6] > MAX_REPS) ||
                      (frames == 16'd0) || (frames > i_cfg.max_frames) ||
                      (expanded > {4'd0, i_cfg.max_exp}) ||
                      (cues > {8'd0, i_cfg.max_cues}) ||
                      ((h[7][0] == 1'b0) != (h[13] == 8'd0));

    always_comb begin
        if (n_count < 32'(HDR_BYTES)) st = ST_TRUNCATED;
        else if (h[0] != 8'h41 || h[1] != 8'h4D || h[2] != 8'h4F || h[3] != 8'h54 ||
                 h[4] != SCHEMA_VER || h[5] != i_cfg.jmap_ver) st = ST_VERSION;
        else if (plen > payload) st = ST_TRUNCATED;
        else if (plen < payload) st = ST_MALFORMED;
        else if ((n_crc ^ CRC_INIT) != crc_hdr) st = ST_CHECKSUM;
        else if (hdr_bad || n_berr || n_phase != PH_DONE) st = ST_MALFORMED;
        else st = ST_OK;
    end

    always_comb begin
        o_result = '0;
        o_result.status = st;
        if (st == ST_OK) begin
            o_result.frames   = frames;
            o_result.repeats  = h[6];
            o_result.cues     = cues[7:0];
            o_result.ret_pose = h[7][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat && in_hdr) r_hdr[pos] <= i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_count <= '0; r_crc <= CRC_INIT; r_phase <= PH_HEADER;
            r_item <= '0; r_sub <= '0; r_hold <= '0; r_seen <= '0;
            r_nend <= 1'b0; r_berr <= 1'b0;
        end else if (i_beat) begin
            r_count <= n_count; r_crc <= n_crc; r_phase <= n_phase;
            r_item <= n_item; r_sub <= n_sub; r_hold <= n_hold; r_seen <= n_seen;
            r_nend <= n_nend; r_berr <= n_berr;
        end
    end

`ifndef SYNTHESIS
    a_phase_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < 32'(HDR_BYTES)) |-> (r_phase == PH_HEADER)) else $error("phase early");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_count == 32'd0 && r_crc == CRC_INIT)) else $error("no clear");
    a_berr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_berr && i_beat && !i_last) |=> r_berr) else $error("error lost");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/motion_asset_stream_validator.sv =====
// Top level: motion file stream validator with result register.
//   channel | signals                           | direction
//   in      | i_valid/o_ready, data, last       | byte beats in
//   out     | o_valid/i_ready, status + counts  | one result per file
//   cfg     | i_cfg_valid/o_cfg_ready, idx/data | register writes
// One byte per cycle; the CRC step and parser update are combinational.
// The result lands in the output register the cycle after the last byte.
// Input stalls only while a result waits and is not being taken.
// Synchronous active-low reset clears parser state and o_valid.
`default_nettype none
module motion_asset_stream_validator #(
    parameter int SERVOS   = 8,
    parameter int NAME_MAX = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_frames_out,
    output logic [7:0]       o_repeats_out,
    output logic [7:0]       o_cues_out,
    output logic             o_has_return_pose,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data
);
    import masv_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_res;
    logic    r_valid;
    logic    beat;

    assign o_ready = !r_valid || i_ready;
    assign beat    = i_valid && o_ready;

    masv_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_cfg(cfg)
    );

    masv_parser #(.SERVOS(SERVOS), .NAME_MAX(NAME_MAX)) u_parse (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_beat(beat), .i_byte(i_data_byte),
        .i_last(i_last_byte), .i_cfg(cfg), .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (beat && i_last_byte) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat && i_last_byte) r_res <= res;
    end

    assign o_valid           = r_valid;
    assign o_status          = r_res.status;
    assign o_frames_out      = r_res.frames;
    assign o_repeats_out     = r_res.repeats;
    assign o_cues_out        = r_res.cues;
    assign o_has_return_pose = r_res.ret_pose;

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready) else $error("result overwritten");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && i_last_byte) |=> o_valid) else $error("result missing");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= 3'd4)) else $error("bad status");
`endif
endmodule
`default_nettype wire

// ===== tb/motion_asset_stream_validator_tb.sv =====
// Testbench for the motion file stream validator: generated files, shadow parser, result checks.
`timescale 1ns / 100ps
module motion_asset_stream_validator_tb;
    import masv_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int BYTE_TARGET  = 1350;

    typedef enum int {
        K_GOOD, K_EDGE, K_NUL_MID,
        K_SHORT_HDR, K_BAD_MAGIC, K_BAD_SCHEMA, K_BAD_JMAP, K_LONG_PLEN, K_SHORT_PLEN,
        K_BAD_CRC, K_BAD_FLAGS, K_RESERVED, K_REPS0, K_REPS17, K_FRAMES0, K_CUES_OVER,
        K_RET_MISMATCH, K_NAME_LEN0, K_NAME_BADCH, K_NAME_NUL0, K_CUE_FRAME, K_CUE_MODE,
        K_DUR_LOW, K_DUR_HIGH, K_TCOUNT0, K_TCOUNT9, K_JOINT_DUP, K_JOINT_OOR, K_CEN_HIGH,
        K_EXTRA, K_EARLY_END,
        K_NOISE
    } t_file_kind;

    typedef struct {
        t_file_kind kind;
        bit         typed;
        t_status    status;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_last_byte = 1'b0;
    logic        i_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = REG_JMAP_VER;
    logic [19:0] i_cfg_data = 20'd0;
    logic        o_ready, o_valid, o_has_return_pose, o_cfg_ready;
    logic [2:0]  o_status;
    logic [15:0] o_frames_out;
    logic [7:0]  o_repeats_out, o_cues_out;

    motion_asset_stream_validator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_last_byte(i_last_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_frames_out(o_frames_out), .o_repeats_out(o_repeats_out),
        .o_cues_out(o_cues_out), .o_has_return_pose(o_has_return_pose),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cfg        cur_cfg;
    t_result     pending_results[$];
    logic [7:0]  file_bytes[$];
    int          failures = 0;
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;
    bit          typed_valid = 1'b0;
    t_status     typed_status = ST_OK;

    // shadow parser state
    logic [31:0] sh_count, sh_crc;
    logic [7:0]  sh_hdr[HDR_BYTES];
    t_phase      sh_phase;
    logic [15:0] sh_item, sh_hold;
    logic [7:0]  sh_sub, sh_seen;
    logic        sh_name_end, sh_body_err;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return r;
    endfunction

    function automatic bit legal_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_";
    endfunction

    function logic [31:0] hdr_u16(input int at);
        return {16'd0, sh_hdr[at + 1], sh_hdr[at]};
    endfunction

    function void clear_parser();
        sh_count = 32'd0;
        sh_crc = 32'hFFFFFFFF;
        foreach (sh_hdr[i]) sh_hdr[i] = 8'd0;
        sh_phase = PH_HEADER;
        sh_item = 16'd0;
        sh_sub = 8'd0;
        sh_hold = 16'd0;
        sh_seen = 8'd0;
        sh_name_end = 1'b0;
        sh_body_err = 1'b0;
    endfunction

    function void open_name(input logic [7:0] len, input t_phase ph);
        if (len == 8'd0 || len > 8'd31) begin
            sh_body_err = 1'b1;
        end else begin
            sh_hold = {8'd0, len};
            sh_sub = 8'd0;
            sh_name_end = 1'b0;
            sh_phase = ph;
        end
    endfunction

    function void goto_frame();
        sh_phase = ({16'd0, sh_item} < hdr_u16(8)) ? PH_DUR_LO : PH_DONE;
    endfunction

    function void goto_cue();
        if ({16'd0, sh_item} < hdr_u16(10)) begin
            sh_phase = PH_CUE_LO;
        end else begin
            sh_item = 16'd0;
            goto_frame();
        end
    endfunction

    function void parse_body(input logic [7:0] b);
        logic [31:0] v;
        case (sh_phase)
            PH_NAME, PH_RETNAME, PH_CUE_NAME: begin
                if (sh_sub == 8'd0 && b == 8'd0) begin
                    sh_body_err = 1'b1;
                    return;
                end
                if (!sh_name_end) begin
                    if (b == 8'd0) sh_name_end = 1'b1;
                    else if (!legal_char(b)) begin
                        sh_body_err = 1'b1;
                        return;
                    end
                end
                sh_sub = sh_sub + 8'd1;
                if ({8'd0, sh_sub} >= sh_hold) begin
                    if (sh_phase == PH_NAME) begin
                        if (sh_hdr[13] != 8'd0) open_name(sh_hdr[13], PH_RETNAME);
                        else begin
                            sh_item = 16'd0;
                            goto_cue();
                        end
                    end else if (sh_phase == PH_RETNAME) begin
                        sh_item = 16'd0;
                        goto_cue();
                    end else begin
                        sh_item = sh_item + 16'd1;
                        goto_cue();
                    end
                end
            end
            PH_CUE_LO: begin
                sh_hold = {8'd0, b};
                sh_phase = PH_CUE_HI;
            end
            PH_CUE_HI: begin
                v = {16'd0, b, sh_hold[7:0]};
                if (v >= hdr_u16(8)) sh_body_err = 1'b1;
                else sh_phase = PH_CUE_MODE;
            end
            PH_CUE_MODE: begin
                if (b > cur_cfg.high_mode) sh_body_err = 1'b1;
                else sh_phase = PH_CUE_NLEN;
            end
            PH_CUE_NLEN: open_name(b, PH_CUE_NAME);
            PH_DUR_LO: begin
                sh_hold = {8'd0, b};
                sh_phase = PH_DUR_HI;
            end
            PH_DUR_HI: begin
                v = {16'd0, b, sh_hold[7:0]};
                if (v < 32'd20 || v > 32'd5000) sh_body_err = 1'b1;
                else sh_phase = PH_TCOUNT;
            end
            PH_TCOUNT: begin
                if (b < 8'd1 || b > 8'd8) sh_body_err = 1'b1;
                else begin
                    sh_hold = {b, 8'd0};
                    sh_sub = 8'd0;
                    sh_seen = 8'd0;
                    sh_phase = PH_JOINT;
                end
            end
            PH_JOINT: begin
                if (b >= 8'd8 || sh_seen[b[2:0]]) sh_body_err = 1'b1;
                else begin
                    sh_seen[b[2:0]] = 1'b1;
                    sh_phase = PH_CEN_LO;
                end
            end
            PH_CEN_LO: begin
                sh_hold = {sh_hold[15:8], b};
                sh_phase = PH_CEN_HI;
            end
            PH_CEN_HI: begin
                v = {16'd0, b, sh_hold[7:0]};
                if (v > 32'd18000) sh_body_err = 1'b1;
                else begin
                    sh_sub = sh_sub + 8'd1;
                    if (sh_sub < sh_hold[15:8]) sh_phase = PH_JOINT;
                    else begin
                        sh_item = sh_item + 16'd1;
                        goto_frame();
                    end
                end
            end
            default: sh_body_err = 1'b1;
        endcase
    endfunction

    function t_status file_status();
        logic [31:0] payload, plen, reps, frames;
        if (sh_count < HDR_BYTES) return ST_TRUNCATED;
        if (sh_hdr[0] != "A" || sh_hdr[1] != "M" || sh_hdr[2] != "O" || sh_hdr[3] != "T" ||
            sh_hdr[4] != 8'h01 || sh_hdr[5] != cur_cfg.jmap_ver)
            return ST_VERSION;
        payload = sh_count - HDR_BYTES;
        plen = {sh_hdr[19], sh_hdr[18], sh_hdr[17], sh_hdr[16]};
        if (plen != payload) return (plen > payload) ? ST_TRUNCATED : ST_MALFORMED;
        if ((sh_crc ^ 32'hFFFFFFFF) != {sh_hdr[23], sh_hdr[22], sh_hdr[21], sh_hdr[20]})
            return ST_CHECKSUM;
        reps = {24'd0, sh_hdr[6]};
        frames = hdr_u16(8);
        if (sh_hdr[7][7:1] != 7'd0 || hdr_u16(14) != 32'd0 || reps < 1 || reps > 16 ||
            frames < 1 || frames > {16'd0, cur_cfg.max_frames} ||
            frames * reps > {12'd0, cur_cfg.max_exp} ||
            hdr_u16(10) > {24'd0, cur_cfg.max_cues} ||
            (sh_hdr[7][0] == 1'b0) != (sh_hdr[13] == 8'd0))
            return ST_MALFORMED;
        if (sh_body_err || sh_phase != PH_DONE) return ST_MALFORMED;
        return ST_OK;
    endfunction

    function void absorb_byte(input logic [7:0] b, input logic last);
        t_result r;
        int pos;
        pos = sh_count;
        if (sh_count != 32'hFFFFFFFF) sh_count = sh_count + 32'd1;
        if (pos < HDR_BYTES) begin
            sh_hdr[pos] = b;
            if (pos == HDR_BYTES - 1) open_name(sh_hdr[12], PH_NAME);
        end else begin
            sh_crc = crc_step(sh_crc, b);
            if (!sh_body_err) parse_body(b);
        end
        if (last) begin
            r = '0;
            r.status = file_status();
            if (r.status == ST_OK) begin
                r.frames = {sh_hdr[9], sh_hdr[8]};
                r.repeats = sh_hdr[6];
                r.cues = sh_hdr[10];
                r.ret_pose = sh_hdr[7][0];
            end
            if (typed_valid) begin
                r = '0;
                r.status = typed_status;
            end
            pending_results.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(0, 36);
        if (r < 26) return 8'h61 + r[7:0];
        if (r < 36) return 8'h30 + r[7:0] - 8'd26;
        return 8'h5F;
    endfunction

    function automatic int min_of(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic void put_name(ref logic [7:0] q[$], input int len,
                                     input t_file_kind k);
        logic [7:0] c;
        for (int j = 0; j < len; j++) begin
            c = name_char();
            if (k == K_NAME_NUL0 && j == 0) c = 8'd0;
            if (k == K_NAME_BADCH && j == len - 1) c = 8'h41;
            if (k == K_NUL_MID && j == 1) c = 8'd0;
            if (k == K_NUL_MID && j > 1) c = 8'($urandom_range(0, 255));
            q.push_back(c);
        end
    endfunction

    function void build_file(input t_file_kind k);
        logic [7:0] body[$];
        logic [7:0] hdr[HDR_BYTES];
        logic [7:0] perm[8];
        logic [7:0] t;
        logic [31:0] crc, plen;
        int nl, rl, nc, nf, reps, tc, dur, cen, sw, cut;
        file_bytes.delete();
        if (k == K_NOISE) begin
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nf = $urandom_range(1, min_of(2, min_of(cur_cfg.max_frames, cur_cfg.max_exp)));
        reps = $urandom_range(1, min_of(16, cur_cfg.max_exp / nf));
        nc = $urandom_range(0, min_of(1, cur_cfg.max_cues));
        if (k == K_CUE_FRAME || k == K_CUE_MODE) nc = 1;
        nl = (k == K_EDGE) ? 31 : $urandom_range((k == K_NUL_MID) ? 3 : 1, 4);
        rl = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : 0;
        if (k == K_EDGE) begin
            rl = 31;
            reps = min_of(16, cur_cfg.max_exp / nf);
        end
        put_name(body, nl, k);
        if (rl != 0) put_name(body, rl, K_GOOD);
        for (int c = 0; c < nc; c++) begin
            t = 8'($urandom_range(0, nf - 1));
            if (k == K_CUE_FRAME) t = 8'(nf);
            body.push_back(t);
            body.push_back(8'd0);
            t = 8'($urandom_range(0, min_of(cur_cfg.high_mode, 5)));
            if (k == K_CUE_MODE) t = cur_cfg.high_mode + 8'd1;
            body.push_back(t);
            tc = $urandom_range(1, 3);
            body.push_back(8'(tc));
            put_name(body, tc, K_GOOD);
        end
        for (int f = 0; f < nf; f++) begin
            dur = $urandom_range(20, 5000);
            if (k == K_EDGE) dur = f[0] ? 5000 : 20;
            if (k == K_DUR_LOW) dur = $urandom_range(0, 19);
            if (k == K_DUR_HIGH) dur = $urandom_range(5001, 65535);
            body.push_back(dur[7:0]);
            body.push_back(dur[15:8]);
            tc = (k == K_EDGE) ? 8 : $urandom_range((k == K_JOINT_DUP) ? 2 : 1, 2);
            if (k == K_TCOUNT0) body.push_back(8'd0);
            else if (k == K_TCOUNT9) body.push_back(8'($urandom_range(9, 255)));
            else body.push_back(8'(tc));
            for (int j = 0; j < 8; j++) perm[j] = 8'(j);
            for (int j = 7; j > 0; j--) begin
                sw = $urandom_range(0, j);
                t = perm[j];
                perm[j] = perm[sw];
                perm[sw] = t;
            end
            for (int j = 0; j < tc; j++) begin
                t = perm[j];
                if (k == K_JOINT_DUP && j == 1) t = perm[0];
                if (k == K_JOINT_OOR && j == 0) t = 8'($urandom_range(8, 255));
                body.push_back(t);
                cen = $urandom_range(0, 18000);
                if (k == K_EDGE) cen = j[0] ? 18000 : 0;
                if (k == K_CEN_HIGH) cen = $urandom_range(18001, 65535);
                body.push_back(cen[7:0]);
                body.push_back(cen[15:8]);
            end
        end
        if (k == K_EXTRA) body.push_back(8'($urandom_range(0, 255)));
        if (k == K_EARLY_END) void'(body.pop_back());
        crc = 32'hFFFFFFFF;
        foreach (body[i]) crc = crc_step(crc, body[i]);
        crc = crc ^ 32'hFFFFFFFF;
        plen = body.size();
        if (k == K_LONG_PLEN) plen = plen + $urandom_range(1, 3);
        if (k == K_SHORT_PLEN) plen = plen - 1;
        if (k == K_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        hdr = '{"A", "M", "O", "T", 8'h01, cur_cfg.jmap_ver, reps[7:0], {7'd0, rl != 0},
                nf[7:0], 8'd0, nc[7:0], 8'd0, nl[7:0], rl[7:0], 8'd0, 8'd0,
                plen[7:0], plen[15:8], plen[23:16], plen[31:24],
                crc[7:0], crc[15:8], crc[23:16], crc[31:24]};
        case (k)
            K_BAD_MAGIC:    hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            K_BAD_SCHEMA:   hdr[4] = 8'($urandom_range(2, 255));
            K_BAD_JMAP:     hdr[5] = cur_cfg.jmap_ver ^ 8'($urandom_range(1, 255));
            K_BAD_FLAGS:    hdr[7] = hdr[7] | 8'($urandom_range(1, 127) << 1);
            K_RESERVED:     hdr[14 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
            K_REPS0:        hdr[6] = 8'd0;
            K_REPS17:       hdr[6] = 8'($urandom_range(17, 255));
            K_FRAMES0:      hdr[8] = 8'd0;
            K_CUES_OVER:    {hdr[11], hdr[10]} = {8'd0, cur_cfg.max_cues} + 16'd1;
            K_RET_MISMATCH: hdr[7][0] = ~hdr[7][0];
            K_NAME_LEN0:    hdr[12] = 8'd0;
            default: ;
        endcase
        foreach (hdr[i]) file_bytes.push_back(hdr[i]);
        foreach (body[i]) file_bytes.push_back(body[i]);
        if (k == K_SHORT_HDR) begin
            cut = $urandom_range(1, HDR_BYTES - 1);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
    endfunction

    task automatic send_file();
        int gap;
        for (int i = 0; i < file_bytes.size(); i++) begin
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data_byte <= file_bytes[i];
            i_last_byte <= (i == file_bytes.size() - 1);
            do @(posedge i_clk); while (!o_ready);
            absorb_byte(file_bytes[i], i == file_bytes.size() - 1);
            bytes_sent++;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_regs(input logic [7:0] jv, input logic [15:0] mf, input logic [19:0] me,
                             input logic [7:0] mc, input logic [7:0] hm);
        logic [19:0] vals[5];
        logic [2:0]  idx[5];
        vals = '{{12'd0, jv}, {4'd0, mf}, me, {12'd0, mc}, {12'd0, hm}};
        idx = '{REG_JMAP_VER, REG_MAX_FRM, REG_MAX_EXP, REG_MAX_CUES, REG_HIGH_MODE};
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cur_cfg = '{jmap_ver: jv, max_frames: mf, max_exp: me, max_cues: mc, high_mode: hm};
    endtask

    task automatic random_files(input int byte_goal, input int result_goal);
        int r0, pick;
        r0 = results_seen;
        while (bytes_sent < byte_goal || results_seen + pending_results.size() - r0 < result_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55) build_file(($urandom_range(0, 4) == 0) ? K_EDGE : K_GOOD);
            else if (pick < 60) build_file(K_NUL_MID);
            else if (pick < 90) build_file(t_file_kind'($urandom_range(K_SHORT_HDR, K_EARLY_END)));
            else build_file(K_NOISE);
            quiet = ($urandom_range(0, 5) == 0);
            send_file();
        end
        quiet = 1'b0;
    endtask

    // hold off result beats, now and then for a long stretch
    initial begin
        int hold;
        forever begin
            hold = $urandom_range(0, 13);
            if (long_hold) begin
                hold = 400;
                long_hold = 1'b0;
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with no expectation: status %0d", o_status);
                failures++;
            end else begin
                t_result e;
                e = pending_results.pop_front();
                if (o_status != e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    failures++;
                end
                if (o_frames_out != e.frames) begin
                    $error("frames_out: expected %0d, got %0d", e.frames, o_frames_out);
                    failures++;
                end
                if (o_repeats_out != e.repeats) begin
                    $error("repeats_out: expected %0d, got %0d", e.repeats, o_repeats_out);
                    failures++;
                end
                if (o_cues_out != e.cues) begin
                    $error("cues_out: expected %0d, got %0d", e.cues, o_cues_out);
                    failures++;
                end
                if (o_has_return_pose != e.ret_pose) begin
                    $error("has_return_pose: expected %0d, got %0d", e.ret_pose,
                           o_has_return_pose);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row rows[];
        rows = '{
            '{K_GOOD, 1'b0, ST_OK},
            '{K_EDGE, 1'b0, ST_OK},
            '{K_NUL_MID, 1'b0, ST_OK},
            '{K_SHORT_HDR, 1'b1, ST_TRUNCATED},
            '{K_BAD_MAGIC, 1'b1, ST_VERSION},
            '{K_BAD_SCHEMA, 1'b1, ST_VERSION},
            '{K_BAD_JMAP, 1'b1, ST_VERSION},
            '{K_LONG_PLEN, 1'b1, ST_TRUNCATED},
            '{K_SHORT_PLEN, 1'b1, ST_MALFORMED},
            '{K_BAD_CRC, 1'b1, ST_CHECKSUM},
            '{K_BAD_FLAGS, 1'b1, ST_MALFORMED},
            '{K_RESERVED, 1'b1, ST_MALFORMED},
            '{K_REPS0, 1'b1, ST_MALFORMED},
            '{K_REPS17, 1'b1, ST_MALFORMED},
            '{K_FRAMES0, 1'b1, ST_MALFORMED},
            '{K_CUES_OVER, 1'b1, ST_MALFORMED},
            '{K_RET_MISMATCH, 1'b1, ST_MALFORMED},
            '{K_NAME_LEN0, 1'b1, ST_MALFORMED},
            '{K_NAME_BADCH, 1'b1, ST_MALFORMED},
            '{K_NAME_NUL0, 1'b1, ST_MALFORMED},
            '{K_CUE_FRAME, 1'b1, ST_MALFORMED},
            '{K_CUE_MODE, 1'b1, ST_MALFORMED},
            '{K_DUR_LOW, 1'b1, ST_MALFORMED},
            '{K_DUR_HIGH, 1'b1, ST_MALFORMED},
            '{K_TCOUNT0, 1'b1, ST_MALFORMED},
            '{K_TCOUNT9, 1'b1, ST_MALFORMED},
            '{K_JOINT_DUP, 1'b1, ST_MALFORMED},
            '{K_JOINT_OOR, 1'b1, ST_MALFORMED},
            '{K_CEN_HIGH, 1'b1, ST_MALFORMED},
            '{K_EXTRA, 1'b1, ST_MALFORMED},
            '{K_EARLY_END, 1'b1, ST_MALFORMED}
        };
        cur_cfg = '{jmap_ver: 8'd1, max_frames: 16'd256, max_exp: 20'd1024, max_cues: 8'd32,
                    high_mode: 8'd2};
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            build_file(rows[i].kind);
            typed_valid = rows[i].typed;
            typed_status = rows[i].status;
            send_file();
        end
        typed_valid = 1'b0;
        random_files(BYTE_TARGET / 5, 2);

        drain();
        load_regs(8'd0, 16'd1, 20'd1, 8'd0, 8'd0);
        random_files(2 * BYTE_TARGET / 5, 2);

        drain();
        load_regs(8'd255, 16'd65535, 20'd1048560, 8'd255, 8'd255);
        long_hold = 1'b1;
        random_files(3 * BYTE_TARGET / 5, 3);

        drain();
        load_regs(8'($urandom_range(0, 255)), 16'($urandom_range(1, 4)),
                  20'($urandom_range(1, 40)), 8'($urandom_range(0, 3)),
                  8'($urandom_range(0, 6)));
        random_files(4 * BYTE_TARGET / 5, 2);

        drain();
        load_regs(8'd1, 16'd256, 20'd1024, 8'd32, 8'd2);
        random_files(BYTE_TARGET, 1);

        drain();
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/masv_pkg.sv
rtl/core/masv_cfg_regs.sv
rtl/core/masv_parser.sv
rtl/core/motion_asset_stream_validator.sv
tb/motion_asset_stream_validator_tb.sv
